// ===== src/fbba_pkg.sv =====
// Shared constants for the fixed-size block bitmap allocator.
// Holds sizes, request kinds, status codes and register indexes.
// No dependencies.
package fbba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 17;
    localparam int COUNT_W    = 9;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;

    // Used bits are scanned one group of eight per cycle.
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = (MAX_BLOCKS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int SUB_W      = $clog2(GROUP_SIZE);
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PROD_W     = COUNT_W + SIZE_W;
    localparam int REM_W      = SIZE_W + 1;
    localparam int DIV_CNT_W  = $clog2(ADDR_W);

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALIGN   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    typedef logic [STATUS_W-1:0] status_t;

endpackage

// ===== src/fixed_block_bitmap_allocator_unit.sv =====
// Fixed-size block allocator over a map of used bits, top level.
// Allocate scans the used bits group by group of eight blocks, then on success does a multiply and
// an add; free does a multiply, a bound check, the restoring divider and a final check, or ends at
// the bound check when out of range; clear all and the unused kind go straight to the result.
// One request at a time; the next is taken from the cycle after the result transfer.
// Synchronous active-low reset clears all used bits and loads register defaults.
module fixed_block_bitmap_allocator_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [fbba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbba_pkg::ADDR_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fbba_pkg::ADDR_W-1:0]     s_tdata,   // [31:0] address
    input  logic [fbba_pkg::KIND_W-1:0]     s_tuser,   // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fbba_pkg::ADDR_W-1:0]     m_tdata,   // [31:0] block_address
    output logic [fbba_pkg::STATUS_W-1:0]   m_tuser    // [2:0] status
);
    import fbba_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_AMUL  = 4'd2;
    localparam logic [3:0] S_AADD  = 4'd3;
    localparam logic [3:0] S_FMUL  = 4'd4;
    localparam logic [3:0] S_FCHK  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FEND  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam int USED_W = NUM_GROUPS * GROUP_SIZE;

    logic [3:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     base_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [GRP_W-1:0]      grp_reg, grp_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [ADDR_W-1:0]     off_reg, off_next;
    logic                  below_reg, below_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ADDR_W-1:0]     quot_reg, quot_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    status_t               status_reg, status_next;
    logic [ADDR_W-1:0]     baddr_reg, baddr_next;

    logic [SIZE_W-1:0]     size_eff;
    logic [COUNT_W-1:0]    count_eff;
    logic [GROUP_SIZE-1:0] word;
    logic [GROUP_SIZE-1:0] avail;
    logic                  found;
    logic [SUB_W-1:0]      found_sub;
    logic [GRP_W+SUB_W:0]  next_grp_start;
    logic [COUNT_W-1:0]    mul_a;
    logic [ADDR_W:0]       off_diff;
    logic [REM_W-1:0]      rem_shift;
    logic                  s_fire;

    assign size_eff  = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign count_eff = (int'(count_reg) > MAX_BLOCKS) ? COUNT_W'(MAX_BLOCKS) : count_reg;
    assign s_fire    = s_tvalid && s_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = baddr_reg;
    assign m_tuser  = status_reg;

    // Scan window: one group of used bits, restricted to blocks below the count.
    always_comb begin
        word = used_reg[grp_reg*GROUP_SIZE +: GROUP_SIZE];
        for (int j = 0; j < GROUP_SIZE; j++) begin
            avail[j] = !word[j] &&
                       ((GRP_W+SUB_W+1)'({grp_reg, SUB_W'(j)}) < (GRP_W+SUB_W+1)'(count_eff));
        end
        found     = 1'b0;
        found_sub = '0;
        for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if (avail[j]) begin
                found     = 1'b1;
                found_sub = SUB_W'(j);
            end
        end
        next_grp_start = {1'b0, grp_reg, {SUB_W{1'b0}}} + (GRP_W+SUB_W+1)'(GROUP_SIZE);
    end

    // The one multiplier serves the allocate address and the free bound.
    assign mul_a    = (state_reg == S_AMUL) ? COUNT_W'(idx_reg) : count_eff;
    assign off_diff = {1'b0, s_tdata} - {1'b0, base_reg};
    assign rem_shift = {rem_reg[REM_W-2:0], quot_reg[ADDR_W-1]};

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        grp_next     = grp_reg;
        idx_next     = idx_reg;
        prod_next    = prod_reg;
        off_next     = off_reg;
        below_next   = below_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        div_cnt_next = div_cnt_reg;
        status_next  = status_reg;
        baddr_next   = baddr_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    status_next = ST_OK;
                    baddr_next  = '0;
                    grp_next    = '0;
                    off_next    = off_diff[ADDR_W-1:0];
                    below_next  = off_diff[ADDR_W];
                    case (s_tuser)
                        KIND_ALLOC: state_next = S_SCAN;
                        KIND_FREE:  state_next = S_FMUL;
                        KIND_CLEAR: begin
                            used_next  = '0;
                            state_next = S_OUT;
                        end
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            S_SCAN: begin
                if (found) begin
                    idx_next = IDX_W'({grp_reg, found_sub});
                    used_next[{grp_reg, found_sub}] = 1'b1;
                    state_next = S_AMUL;
                end else if (int'(grp_reg) == NUM_GROUPS - 1 ||
                             next_grp_start >= (GRP_W+SUB_W+1)'(count_eff)) begin
                    status_next = ST_NO_FREE;
                    state_next  = S_OUT;
                end else begin
                    grp_next = grp_reg + GRP_W'(1);
                end
            end
            S_AMUL: begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(size_eff);
                state_next = S_AADD;
            end
            S_AADD: begin
                baddr_next = base_reg + ADDR_W'(prod_reg);
                state_next = S_OUT;
            end
            S_FMUL: begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(size_eff);
                state_next = S_FCHK;
            end
            S_FCHK: begin
                if (below_reg || off_reg >= ADDR_W'(prod_reg)) begin
                    status_next = ST_RANGE;
                    state_next  = S_OUT;
                end else begin
                    rem_next     = '0;
                    quot_next    = off_reg;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (rem_shift >= REM_W'(size_eff)) begin
                    rem_next  = rem_shift - REM_W'(size_eff);
                    quot_next = {quot_reg[ADDR_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_shift;
                    quot_next = {quot_reg[ADDR_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (int'(div_cnt_reg) == ADDR_W - 1) begin
                    state_next = S_FEND;
                end
            end
            S_FEND: begin
                // The bound check keeps the quotient below the block count.
                if (rem_reg != '0) begin
                    status_next = ST_ALIGN;
                end else if (!used_reg[quot_reg[IDX_W-1:0]]) begin
                    status_next = ST_FREE;
                end else begin
                    used_next[quot_reg[IDX_W-1:0]] = 1'b0;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            base_reg   <= '0;
            size_reg   <= SIZE_W'(64);
            count_reg  <= COUNT_W'(256);
            status_reg <= ST_OK;
            baddr_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            status_reg <= status_next;
            baddr_reg  <= baddr_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_BASE:  base_reg  <= cfg_wdata;
                    REG_SIZE:  size_reg  <= cfg_wdata[SIZE_W-1:0];
                    REG_COUNT: count_reg <= cfg_wdata[COUNT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg     <= grp_next;
        idx_reg     <= idx_next;
        prod_reg    <= prod_next;
        off_reg     <= off_next;
        below_reg   <= below_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        div_cnt_reg <= div_cnt_next;
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result sides open at the same time");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_addr_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("nonzero block address on a failed request");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FEND) |-> ($past(state_reg) == S_DIV) && (div_cnt_reg == '0))
        else $error("divider finished without a full pass");

endmodule
